@@ src/cwpa_pkg.sv @@
// Shared types and constants of the communication watchdog with panic alarm.
package cwpa_pkg;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_MONITOR = 2'd1,
    MODE_PANIC   = 2'd2
  } mode_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERTIME = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM    = 8'd1;

  localparam logic [7:0] OVERTIME_RESET = 8'd5;
  localparam logic [7:0] ALARM_RESET    = 8'd20;
  localparam logic [7:0] SECONDS_MAX    = 8'd255;

  // command and reply characters
  localparam logic [7:0] CMD_OFF     = 8'h6F; // 'o'
  localparam logic [7:0] CMD_MONITOR = 8'h6D; // 'm'
  localparam logic [7:0] CMD_PANIC   = 8'h70; // 'p'
  localparam logic [7:0] REPLY_OFF     = 8'h4F; // 'O'
  localparam logic [7:0] REPLY_MONITOR = 8'h4D; // 'M'
  localparam logic [7:0] REPLY_PANIC   = 8'h50; // 'P'

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_IDX_W = 2;
  localparam int QUEUE_LVL_W = 3;

  typedef struct packed {
    logic       led_out;
    logic       relay_out;
    logic       buzzer_out;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
  } result_t;

  // results produced by one accepted item
  typedef struct packed {
    logic       two;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

@@ src/cwpa_if.sv @@
// Channel interfaces: input items, result items and configuration writes.
interface cwpa_in_if;
  logic       valid;
  logic       ready;
  logic       second_tick;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       button_level;

  modport source (output valid, second_tick, rx_valid, rx_byte, button_level, input ready);
  modport sink   (input valid, second_tick, rx_valid, rx_byte, button_level, output ready);
endinterface

interface cwpa_out_if;
  logic       valid;
  logic       ready;
  logic       led_out;
  logic       relay_out;
  logic       buzzer_out;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       last;

  modport source (output valid, led_out, relay_out, buzzer_out, tx_valid, tx_byte, last,
                  input ready);
  modport sink   (input valid, led_out, relay_out, buzzer_out, tx_valid, tx_byte, last,
                  output ready);
endinterface

interface cwpa_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/comm_watchdog_panic_alarm.sv @@
// Top level of the communication watchdog with panic alarm.
// Each input item is one control-loop pass and is decided in the cycle it is
// transferred in; its one or two results go into a four-entry result queue that
// drives the output channel from registers. An item is taken whenever at most
// two results are queued, so with a ready sink the block runs one item per
// cycle unless two-result items fill the queue; such an item queues two results,
// and the output side is what limits the sustained rate to one result per cycle.
// Configuration writes are always taken and take effect in the cycle after.
module comm_watchdog_panic_alarm import cwpa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  cwpa_in_if.sink    in_ch,
  cwpa_out_if.source out_ch,
  cwpa_cfg_if.sink   cfg_ch
);

  logic                   in_take;
  logic                   out_take;
  push_t                  push;
  result_t                head;
  logic [QUEUE_LVL_W-1:0] level;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (level <= QUEUE_LVL_W'(QUEUE_DEPTH - 2));
  assign in_take      = in_ch.valid && in_ch.ready;
  assign out_take     = out_ch.valid && out_ch.ready;

  cwpa_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_ch.valid && cfg_ch.ready),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .item_take    (in_take),
    .second_tick  (in_ch.second_tick),
    .rx_valid     (in_ch.rx_valid),
    .rx_byte      (in_ch.rx_byte),
    .button_level (in_ch.button_level),
    .push         (push)
  );

  cwpa_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_en (in_take),
    .push    (push),
    .pop     (out_take),
    .head    (head),
    .level   (level)
  );

  assign out_ch.valid      = (level != '0);
  assign out_ch.led_out    = head.led_out;
  assign out_ch.relay_out  = head.relay_out;
  assign out_ch.buzzer_out = head.buzzer_out;
  assign out_ch.tx_valid   = head.tx_valid;
  assign out_ch.tx_byte    = head.tx_byte;
  assign out_ch.last       = head.last;

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= QUEUE_LVL_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_first_has_second: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last) |-> (level >= QUEUE_LVL_W'(2)))
    else $error("non-final result without its follow-up queued");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.tx_valid) |-> (out_ch.tx_byte == 8'd0 && out_ch.last))
    else $error("result without a byte carries data or is not final");

  a_push_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && push.two) |-> (push.first.tx_valid && !push.first.last &&
                               push.second.tx_byte == REPLY_PANIC))
    else $error("malformed two-result pass");

endmodule

@@ src/cwpa_ctrl.sv @@
// Watchdog state, configuration registers and the per-pass decision logic.
module cwpa_ctrl import cwpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 item_take,
  input  logic                 second_tick,
  input  logic                 rx_valid,
  input  logic [7:0]           rx_byte,
  input  logic                 button_level,
  output push_t                push
);

  logic [7:0] overtime_r, alarm_r;
  mode_t      mode_r, mode_nxt;
  logic [7:0] elapsed_r, elapsed_nxt;
  logic       latched_r, latched_nxt;
  logic       held_r, held_nxt;
  logic       led_r, led_nxt;
  logic       relay_r, relay_nxt;
  logic       buzzer_r, buzzer_nxt;

  logic [1:0] sent;
  logic [7:0] byte0, byte1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overtime_r <= OVERTIME_RESET;
      alarm_r    <= ALARM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_OVERTIME) overtime_r <= cfg_data;
      if (cfg_index == CFG_ALARM)    alarm_r    <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_OFF;
      elapsed_r <= '0;
      latched_r <= 1'b0;
      held_r    <= 1'b0;
      led_r     <= 1'b0;
      relay_r   <= 1'b0;
      buzzer_r  <= 1'b0;
    end else if (item_take) begin
      mode_r    <= mode_nxt;
      elapsed_r <= elapsed_nxt;
      latched_r <= latched_nxt;
      held_r    <= held_nxt;
      led_r     <= led_nxt;
      relay_r   <= relay_nxt;
      buzzer_r  <= buzzer_nxt;
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    latched_nxt = latched_r;
    held_nxt    = held_r;
    led_nxt     = led_r;
    relay_nxt   = relay_r;
    buzzer_nxt  = buzzer_r;
    sent        = 2'd0;
    byte0       = '0;
    byte1       = '0;

    elapsed_nxt = (second_tick && elapsed_r != SECONDS_MAX) ? elapsed_r + 8'd1 : elapsed_r;

    // received command; while latched only 'o' gets through
    if (rx_valid) begin
      if (!latched_r || rx_byte == CMD_OFF) begin
        priority if (rx_byte == CMD_OFF) begin
          mode_nxt    = MODE_OFF;
          elapsed_nxt = '0;
          latched_nxt = 1'b0;
          byte0       = REPLY_OFF;
          sent        = 2'd1;
        end else if (rx_byte == CMD_MONITOR) begin
          mode_nxt    = MODE_MONITOR;
          elapsed_nxt = '0;
          byte0       = REPLY_MONITOR;
          sent        = 2'd1;
        end else if (rx_byte == CMD_PANIC) begin
          mode_nxt    = MODE_PANIC;
          elapsed_nxt = '0;
          byte0       = REPLY_PANIC;
          sent        = 2'd1;
        end else begin
          sent = 2'd0;
        end
      end else begin
        byte0 = REPLY_PANIC;
        sent  = 2'd1;
      end
    end

    // press edge latches panic
    if (!button_level && !held_r && !latched_nxt) begin
      held_nxt    = 1'b1;
      latched_nxt = 1'b1;
      mode_nxt    = MODE_PANIC;
      elapsed_nxt = '0;
      if (sent == 2'd0) byte0 = REPLY_PANIC;
      else              byte1 = REPLY_PANIC;
      sent = sent + 2'd1;
    end else if (button_level) begin
      held_nxt = 1'b0;
    end

    unique case (mode_nxt)
      MODE_MONITOR: begin
        led_nxt    = 1'b0;
        relay_nxt  = 1'b0;
        buzzer_nxt = 1'b0;
        if (elapsed_nxt > overtime_r) begin
          mode_nxt    = MODE_PANIC;
          elapsed_nxt = '0;
        end
      end
      MODE_PANIC: begin
        if (elapsed_nxt < alarm_r) begin
          led_nxt    = elapsed_nxt[0];
          buzzer_nxt = elapsed_nxt[0];
        end else begin
          led_nxt    = 1'b1;
          buzzer_nxt = 1'b0;
          relay_nxt  = 1'b1;
          if (!latched_nxt) begin
            latched_nxt = 1'b1;
            // report slot is free here: a button latch would have set the flag
            if (sent == 2'd0) byte0 = REPLY_PANIC;
            else              byte1 = REPLY_PANIC;
            sent = sent + 2'd1;
          end
        end
      end
      default: begin
        led_nxt    = 1'b0;
        relay_nxt  = 1'b0;
        buzzer_nxt = 1'b0;
      end
    endcase
  end

  always_comb begin
    push.two               = (sent == 2'd2);
    push.first.led_out     = led_nxt;
    push.first.relay_out   = relay_nxt;
    push.first.buzzer_out  = buzzer_nxt;
    push.first.tx_valid    = (sent != 2'd0);
    push.first.tx_byte     = byte0;
    push.first.last        = (sent != 2'd2);
    push.second.led_out    = led_nxt;
    push.second.relay_out  = relay_nxt;
    push.second.buzzer_out = buzzer_nxt;
    push.second.tx_valid   = 1'b1;
    push.second.tx_byte    = byte1;
    push.second.last       = 1'b1;
  end

endmodule

@@ src/cwpa_outq.sv @@
// Four-entry result queue: takes one or two results per cycle, hands out one.
module cwpa_outq import cwpa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_en,
  input  push_t                  push,
  input  logic                   pop,
  output result_t                head,
  output logic [QUEUE_LVL_W-1:0] level
);

  result_t                q_r   [QUEUE_DEPTH];
  result_t                q_nxt [QUEUE_DEPTH];
  logic [QUEUE_LVL_W-1:0] level_r, level_nxt;
  logic [QUEUE_IDX_W-1:0] slot;

  always_comb begin
    q_nxt     = q_r;
    level_nxt = level_r;
    // shift down on a transfer out
    if (pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) q_nxt[i] = q_r[i+1];
      level_nxt = level_nxt - QUEUE_LVL_W'(1);
    end
    slot = level_nxt[QUEUE_IDX_W-1:0];
    if (push_en) begin
      q_nxt[slot] = push.first;
      if (push.two) q_nxt[slot + QUEUE_IDX_W'(1)] = push.second;
      level_nxt = level_nxt + (push.two ? QUEUE_LVL_W'(2) : QUEUE_LVL_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) level_r <= '0;
    else        level_r <= level_nxt;
  end

  assign head  = q_r[0];
  assign level = level_r;

endmodule

@@ tb/cwpa_pass_checker.sv @@
// Watches the three channels, predicts each loop pass and checks every result transfer.
module cwpa_pass_checker import cwpa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       in_second_tick,
  input  logic       in_rx_valid,
  input  logic [7:0] in_rx_byte,
  input  logic       in_button_level,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_led_out,
  input  logic       out_relay_out,
  input  logic       out_buzzer_out,
  input  logic       out_tx_valid,
  input  logic [7:0] out_tx_byte,
  input  logic       out_last,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       run_done,
  output int         fail_count,
  output int         outstanding,
  output int         results_seen,
  output int         bytes_seen
);

  localparam int REPORT_MAX = 10;

  logic [7:0] overtime_lim;
  logic [7:0] alarm_lim;
  mode_t      mode;
  logic [7:0] secs;
  logic       latched;
  logic       held;
  logic       led;
  logic       relay;
  logic       buzzer;
  logic [7:0] reply_buf [2];
  int         reply_cnt;
  result_t    due_results [$];
  int         mismatches;

  assign fail_count = mismatches + (run_done ? outstanding : 0);

  function automatic void send_reply(input logic [7:0] b);
    if (reply_cnt < 2) begin
      reply_buf[reply_cnt] = b;
      reply_cnt++;
    end
  endfunction

  function automatic void switch_mode(input mode_t m);
    mode = m;
    secs = '0;
  endfunction

  function automatic void lamps_off();
    led    = 1'b0;
    relay  = 1'b0;
    buzzer = 1'b0;
  endfunction

  // one control-loop pass: update the state and queue the results it causes
  function automatic void run_loop_pass(input logic tick, input logic rxv,
                                        input logic [7:0] rxb, input logic lvl);
    result_t r;
    int      n;
    reply_cnt = 0;

    if (tick && secs != SECONDS_MAX) secs++;

    if (rxv) begin
      if (!latched || rxb == CMD_OFF) begin
        if (rxb == CMD_OFF) begin
          switch_mode(MODE_OFF);
          send_reply(REPLY_OFF);
          latched = 1'b0;
        end else if (rxb == CMD_MONITOR) begin
          switch_mode(MODE_MONITOR);
          send_reply(REPLY_MONITOR);
        end else if (rxb == CMD_PANIC) begin
          switch_mode(MODE_PANIC);
          send_reply(REPLY_PANIC);
        end
      end else begin
        // latched: anything but off just gets a panic reply
        send_reply(REPLY_PANIC);
      end
    end

    if (!lvl && !held && !latched) begin
      held    = 1'b1;
      latched = 1'b1;
      send_reply(REPLY_PANIC);
      switch_mode(MODE_PANIC);
    end else if (lvl) begin
      held = 1'b0;
    end

    case (mode)
      MODE_MONITOR: begin
        lamps_off();
        if (secs > overtime_lim) switch_mode(MODE_PANIC);
      end
      MODE_PANIC: begin
        if (secs < alarm_lim) begin
          led    = secs[0];
          buzzer = secs[0];
        end else begin
          led    = 1'b1;
          buzzer = 1'b0;
          relay  = 1'b1;
          if (!latched) begin
            send_reply(REPLY_PANIC);
            latched = 1'b1;
          end
        end
      end
      default: lamps_off();
    endcase

    n = (reply_cnt == 0) ? 1 : reply_cnt;
    for (int k = 0; k < n; k++) begin
      r.led_out    = led;
      r.relay_out  = relay;
      r.buzzer_out = buzzer;
      r.tx_valid   = (reply_cnt != 0);
      r.tx_byte    = (reply_cnt == 0) ? 8'h00 : reply_buf[k];
      r.last       = (k == n - 1);
      due_results.push_back(r);
    end
  endfunction

  function automatic void note_failure(input string what, input result_t want,
                                       input result_t got);
    if (mismatches < REPORT_MAX)
      $display("checker: %s at %0t: expected led %0b relay %0b buzzer %0b tx %0b/%02h last %0b,",
               what, $realtime, want.led_out, want.relay_out, want.buzzer_out,
               want.tx_valid, want.tx_byte, want.last,
               " got led %0b relay %0b buzzer %0b tx %0b/%02h last %0b",
               got.led_out, got.relay_out, got.buzzer_out, got.tx_valid, got.tx_byte,
               got.last);
    mismatches++;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      overtime_lim = OVERTIME_RESET;
      alarm_lim    = ALARM_RESET;
      mode         = MODE_OFF;
      secs         = '0;
      latched      = 1'b0;
      held         = 1'b0;
      lamps_off();
      due_results.delete();
      mismatches   = 0;
      results_seen = 0;
      bytes_seen   = 0;
    end else begin
      // check results before predicting: a result never comes from this edge's input
      if (out_valid && out_ready) begin
        got = '{out_led_out, out_relay_out, out_buzzer_out, out_tx_valid, out_tx_byte,
                out_last};
        results_seen++;
        if (out_tx_valid) bytes_seen++;
        if (due_results.size() == 0) begin
          note_failure("unexpected result", '0, got);
        end else begin
          want = due_results.pop_front();
          if (got.led_out !== want.led_out || got.relay_out !== want.relay_out ||
              got.buzzer_out !== want.buzzer_out || got.tx_valid !== want.tx_valid ||
              got.tx_byte !== want.tx_byte || got.last !== want.last)
            note_failure("result mismatch", want, got);
        end
      end
      // a pass in this edge still sees the limits from before this edge's write
      if (in_valid && in_ready)
        run_loop_pass(in_second_tick, in_rx_valid, in_rx_byte, in_button_level);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OVERTIME: overtime_lim = cfg_data;
          CFG_ALARM:    alarm_lim    = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = due_results.size();
  end

  always @(posedge run_done) begin
    if (outstanding != 0)
      $display("checker: %0d expected results never arrived", outstanding);
  end

endmodule

@@ tb/comm_watchdog_panic_alarm_tb.sv @@
// Stimulus and verdict for the communication watchdog with panic alarm.
module comm_watchdog_panic_alarm_tb;
  import cwpa_pkg::*;

  localparam int RESET_CYCLES  = 11;
  localparam int IDLE_PCT      = 31;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int NUM_PHASES    = 6;

  typedef struct packed {
    logic       tick;
    logic       rxv;
    logic [7:0] rxb;
    logic       lvl;
  } pass_t;

  typedef enum int {SC_HEARTBEAT, SC_SILENT, SC_PANIC, SC_BUTTON, SC_NOISE} scenario_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   no_idle;
  bit   holdoff_req;
  logic run_done;
  int   passes_sent;
  int   cfg_writes;
  int   fail_count;
  int   outstanding;
  int   results_seen;
  int   bytes_seen;

  // limits per phase: mid, zero, full scale, top of range, reset values, random
  logic [7:0] overtime_set [NUM_PHASES] = '{8'd3, 8'd0, 8'd255, 8'd254, 8'd5, 8'd0};
  logic [7:0] alarm_set    [NUM_PHASES] = '{8'd6, 8'd0, 8'd255, 8'd254, 8'd20, 8'd0};
  logic [7:0] quiet_cmd    [NUM_PHASES] = '{8'h00, 8'h00, CMD_MONITOR, CMD_PANIC, 8'h00, 8'h00};
  int         quiet_len    [NUM_PHASES] = '{0, 0, 270, 260, 0, 0};
  int         stretch_len  [NUM_PHASES] = '{200, 200, 60, 60, 200, 200};

  cwpa_in_if  in_ch ();
  cwpa_out_if out_ch ();
  cwpa_cfg_if cfg_ch ();

  always #5 clk = ~clk;

  comm_watchdog_panic_alarm u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  cwpa_pass_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_second_tick  (in_ch.second_tick),
    .in_rx_valid     (in_ch.rx_valid),
    .in_rx_byte      (in_ch.rx_byte),
    .in_button_level (in_ch.button_level),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_led_out     (out_ch.led_out),
    .out_relay_out   (out_ch.relay_out),
    .out_buzzer_out  (out_ch.buzzer_out),
    .out_tx_valid    (out_ch.tx_valid),
    .out_tx_byte     (out_ch.tx_byte),
    .out_last        (out_ch.last),
    .cfg_valid       (cfg_ch.valid),
    .cfg_ready       (cfg_ch.ready),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .run_done        (run_done),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_seen    (results_seen),
    .bytes_seen      (bytes_seen)
  );

  function automatic pass_t pass_of(input logic t, input logic rv, input logic [7:0] rb,
                                    input logic l);
    pass_t p;
    p.tick = t;
    p.rxv  = rv;
    p.rxb  = rb;
    p.lvl  = l;
    return p;
  endfunction

  function automatic logic [7:0] pick_cmd();
    int w;
    w = $urandom_range(0, 9);
    if (w < 3) return CMD_OFF;
    if (w < 6) return CMD_MONITOR;
    if (w < 9) return CMD_PANIC;
    return 8'($urandom_range(0, 255));
  endfunction

  // enter at a falling edge, leave at the falling edge after the transfer
  task automatic drive_pass(input pass_t p);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.second_tick  <= p.tick;
    in_ch.rx_valid     <= p.rxv;
    in_ch.rx_byte      <= p.rxb;
    in_ch.button_level <= p.lvl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    passes_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // hold the input and wait for every expected result
  task automatic drain();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_stretch(input int n_items);
    int        done_cnt;
    int        w;
    int        burst;
    scenario_t sc;
    pass_t     p;
    done_cnt = 0;
    while (done_cnt < n_items) begin
      w  = $urandom_range(0, 99);
      sc = (w < 20) ? SC_HEARTBEAT : (w < 45) ? SC_SILENT : (w < 70) ? SC_PANIC :
           (w < 85) ? SC_BUTTON : SC_NOISE;
      burst = $urandom_range(4, 30);
      for (int k = 0; k < burst && done_cnt < n_items; k++) begin
        p = pass_of(1'($urandom_range(0, 1)), 1'b0, 8'($urandom_range(0, 255)),
                    $urandom_range(0, 99) >= 3);
        case (sc)
          SC_HEARTBEAT: begin
            if (k == 0 || $urandom_range(0, 99) < 30) begin
              p.rxv = 1'b1;
              p.rxb = CMD_MONITOR;
            end
          end
          SC_SILENT: begin
            // leave any latch, start monitoring, then let the heartbeat lapse
            p.tick = $urandom_range(0, 99) < 75;
            if (k < 2) begin
              p.rxv = 1'b1;
              p.rxb = (k == 0) ? CMD_OFF : CMD_MONITOR;
            end
          end
          SC_PANIC: begin
            p.tick = $urandom_range(0, 99) < 75;
            if (k < 2) begin
              p.rxv = 1'b1;
              p.rxb = (k == 0) ? CMD_OFF : CMD_PANIC;
            end else if ($urandom_range(0, 99) < 10) begin
              p.rxv = 1'b1;
              p.rxb = pick_cmd();
            end
          end
          SC_BUTTON: begin
            p.lvl = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 15) begin
              p.rxv = 1'b1;
              p.rxb = pick_cmd();
            end
          end
          default: begin
            p.rxv = 1'($urandom_range(0, 1));
            p.lvl = 1'($urandom_range(0, 1));
          end
        endcase
        drive_pass(p);
        done_cnt++;
      end
    end
  endtask

  // sink side: random back-pressure, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holdoff_req = 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [7:0] ot;
    logic [7:0] al;
    in_ch.valid        = 1'b0;
    in_ch.second_tick  = 1'b0;
    in_ch.rx_valid     = 1'b0;
    in_ch.rx_byte      = 8'h00;
    in_ch.button_level = 1'b1;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_OVERTIME;
    cfg_ch.data        = 8'h00;
    rst_n              = 1'b0;
    run_done           = 1'b0;
    no_idle            = 1'b0;
    holdoff_req        = 1'b0;
    passes_sent        = 0;
    cfg_writes         = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // short limits so timeouts and the relay latch come quickly
    write_reg(CFG_OVERTIME, 8'd1);
    write_reg(CFG_ALARM, 8'd2);
    drive_pass(pass_of(1'b0, 1'b0, 8'h00, 1'b1));
    drive_pass(pass_of(1'b1, 1'b0, 8'hFF, 1'b1));
    drive_pass(pass_of(1'b0, 1'b1, CMD_MONITOR, 1'b1));
    repeat (4) drive_pass(pass_of(1'b1, 1'b0, 8'h00, 1'b1));
    // latched: commands answered with a panic reply, a press is ignored
    drive_pass(pass_of(1'b0, 1'b1, CMD_MONITOR, 1'b1));
    drive_pass(pass_of(1'b0, 1'b1, 8'h00, 1'b1));
    drive_pass(pass_of(1'b0, 1'b0, 8'h00, 1'b0));
    drive_pass(pass_of(1'b0, 1'b0, 8'h00, 1'b1));
    drive_pass(pass_of(1'b0, 1'b1, CMD_OFF, 1'b1));
    drive_pass(pass_of(1'b0, 1'b1, 8'hFF, 1'b1));
    drive_pass(pass_of(1'b0, 1'b0, 8'h00, 1'b0));
    drive_pass(pass_of(1'b1, 1'b0, 8'h00, 1'b0));
    drive_pass(pass_of(1'b0, 1'b1, CMD_OFF, 1'b0));
    drive_pass(pass_of(1'b0, 1'b0, 8'h00, 1'b1));
    // panic command and a press in one pass: two replies
    drive_pass(pass_of(1'b0, 1'b1, CMD_PANIC, 1'b0));
    drive_pass(pass_of(1'b0, 1'b1, CMD_OFF, 1'b1));

    drain();
    write_reg(CFG_ALARM, 8'd0);
    write_reg(CFG_OVERTIME, 8'd0);
    // zero alarm time: echo and report in the same pass
    drive_pass(pass_of(1'b0, 1'b1, CMD_PANIC, 1'b1));
    drive_pass(pass_of(1'b0, 1'b1, CMD_OFF, 1'b1));
    drive_pass(pass_of(1'b1, 1'b1, CMD_MONITOR, 1'b1));
    drive_pass(pass_of(1'b1, 1'b0, 8'h00, 1'b1));
    drive_pass(pass_of(1'b0, 1'b1, CMD_OFF, 1'b1));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      ot = overtime_set[ph];
      al = alarm_set[ph];
      if (ph == NUM_PHASES - 1) begin
        ot = 8'($urandom_range(1, 12));
        al = 8'($urandom_range(1, 12));
      end
      write_reg(CFG_OVERTIME, ot);
      write_reg(CFG_ALARM, al);
      no_idle = (ph == 4);
      if (quiet_len[ph] != 0) begin
        // long tick run with no traffic: counter saturates
        drive_pass(pass_of(1'b0, 1'b1, CMD_OFF, 1'b1));
        drive_pass(pass_of(1'b0, 1'b1, quiet_cmd[ph], 1'b1));
        repeat (quiet_len[ph])
          drive_pass(pass_of(1'b1, 1'b0, 8'($urandom_range(0, 255)), 1'b1));
      end
      if (ph == 0) holdoff_req = 1'b1;
      random_stretch(stretch_len[ph]);
    end
    no_idle = 1'b0;

    drain();
    run_done = 1'b1;
    @(negedge clk);
    $display("summary: %0d loop passes, %0d results checked, %0d reply bytes",
             passes_sent, results_seen, bytes_seen);
    $display("summary: %0d register writes over eight limit settings, zero and full scale too",
             cfg_writes);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/cwpa_pkg.sv
src/cwpa_if.sv
src/cwpa_ctrl.sv
src/cwpa_outq.sv
src/comm_watchdog_panic_alarm.sv
tb/cwpa_pass_checker.sv
tb/comm_watchdog_panic_alarm_tb.sv
